FILE: rtl/clsp_pkg.sv
// Package for the curvature-limited speed core: widths, register indexes, constants.
// Used by every module in rtl/.
package clsp_pkg;
   localparam int WINDOW_DEPTH = 8;
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NORM      = 3'd4;
   localparam logic [16:0] SCORE_ONE = 17'd65536;
   localparam int DIV_W = 64;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;
endpackage

FILE: rtl/curvature_limited_speed_profile_core.sv
// Curvature-limited speed profile core. Each request (position, timestamp) enters an
// 8-deep sample ring and gives one response: speed and Q1.16 curvature score.
// A request runs the error ramp division, one division per sample pair with a nonzero
// time step, then the mean, score and reduction steps on the shared bit-serial 64-bit
// divider and the shift-add multiplier. A finished request waits in the last state
// while the previous response is still held.
// Depends on clsp_pkg, clsp_div.
module curvature_limited_speed_profile_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [47:0] req_tdata,   // [15:0] position, [47:16] timestamp_ms
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] speed, [28:12] curvature_score, zero pad
   input  logic csr_we,
   input  logic [clsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [clsp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import clsp_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_PAIR = 4'd1, ST_PDIV = 4'd2,
      ST_MEAN = 4'd3, ST_MDIV = 4'd4, ST_SDIV = 4'd5, ST_MUL1 = 4'd6,
      ST_MUL2 = 4'd7, ST_RDIV = 4'd8, ST_OUT = 4'd9, ST_WAIT = 4'd10,
      ST_PACC = 4'd11;

   logic [11:0] min_ff, max_ff;
   logic [14:0] thr_ff;
   logic [17:0] wgt_ff;
   logic [31:0] norm_ff;

   logic [15:0] pos_mem [WINDOW_DEPTH];
   logic [31:0] tim_mem [WINDOW_DEPTH];
   logic [PTR_W-1:0] wp_ff;
   logic [CNT_W-1:0] fill_ff;

   logic [3:0] st_ff, st_in;
   logic [PTR_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] pairs_ff, pairs_in;
   logic [63:0] sum_ff, sum_in;
   logic [16:0] score_ff, score_in;
   logic [15:0] pabs_ff;
   logic [63:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [31:0] mp_ff, mp_in;
   logic [5:0] mcnt_ff, mcnt_in;
   logic [11:0] errspd_ff, errspd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [28:0] rsp_data_ff, rsp_data_in;
   logic [15:0] ppos_ff, cpos_ff;
   logic [31:0] ptim_ff, ctim_ff;

   div_req_type dreq;
   logic dbusy;
   logic [63:0] dq, dr;

   clsp_div u_div (.clock, .reset, .div_req(dreq), .busy(dbusy), .quot(dq), .remd(dr));

   logic [11:0] d12;
   logic [PTR_W-1:0] base, ip, ic;
   logic signed [16:0] dp;
   logic [16:0] dpa;
   logic [31:0] dt;
   logic [16:0] pin_abs;
   logic [13:0] red;
   logic signed [15:0] effmax, spd;
   logic accept;

   assign d12 = max_ff - min_ff;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign base = wp_ff - PTR_W'(fill_ff);
   assign dp = $signed({cpos_ff[15], cpos_ff}) - $signed({ppos_ff[15], ppos_ff});
   assign dpa = dp[16] ? 17'(-dp) : 17'(dp);
   assign dt = ctim_ff - ptim_ff;
   assign pin_abs = req_tdata[15] ? 17'(-$signed({1'b1, req_tdata[15:0]}))
                                  : {1'b0, req_tdata[15:0]};

   // Ring reads are registered; pair k uses entries base+k and base+k+1.
   assign ip = base + k_ff;
   assign ic = base + k_ff + PTR_W'(1);
   always_ff @(posedge clock) begin
      ppos_ff <= pos_mem[ip]; cpos_ff <= pos_mem[ic];
      ptim_ff <= tim_mem[ip]; ctim_ff <= tim_mem[ic];
      if (accept) begin
         pos_mem[wp_ff] <= req_tdata[15:0];
         tim_mem[wp_ff] <= req_tdata[47:16];
      end
   end

   always_comb begin
      st_in = st_ff; k_in = k_ff; pairs_in = pairs_ff; sum_in = sum_ff;
      score_in = score_ff; acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff;
      mcnt_in = mcnt_ff; errspd_in = errspd_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      dreq = '0; red = '0; effmax = '0; spd = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (st_ff)
         ST_IDLE: if (accept) begin
            k_in = '0; pairs_in = '0; sum_in = '0; score_in = '0;
            // error ramp: start p*d/thr division now, finish in ST_WAIT
            st_in = ST_WAIT;
            dreq.start = 1'b1;
            dreq.num = 64'(pin_abs) * 64'(d12);
            dreq.den = 64'(thr_ff);
         end
         ST_WAIT: if (!dbusy) begin
            if (min_ff >= max_ff || pabs_ff == 16'd0) errspd_in = max_ff;
            else if (17'(pabs_ff) >= 17'(thr_ff) || pabs_ff[15]) errspd_in = min_ff;
            else errspd_in = max_ff - 12'(dq + 64'(dr != 0));
            st_in = (fill_ff < CNT_W'(2)) ? ST_MEAN : ST_PAIR;
         end
         ST_PAIR: st_in = ST_PDIV; // memory read latency
         ST_PDIV: if (dt != 0) begin
            dreq.start = 1'b1; dreq.num = 64'(dpa) << 16; dreq.den = 64'(dt);
            pairs_in = pairs_ff + CNT_W'(1);
            st_in = ST_PACC;
         end else begin
            k_in = k_ff + PTR_W'(1);
            st_in = (CNT_W'(k_ff) + CNT_W'(2) >= fill_ff) ? ST_MEAN : ST_PAIR;
         end
         ST_PACC: if (!dbusy) begin
            sum_in = sum_ff + dq; k_in = k_ff + PTR_W'(1);
            st_in = (CNT_W'(k_ff) + CNT_W'(2) >= fill_ff) ? ST_MEAN : ST_PAIR;
         end
         ST_MEAN: if (pairs_ff == '0) begin
            score_in = '0; st_in = ST_MUL1;
         end else begin
            dreq.start = 1'b1; dreq.num = sum_ff; dreq.den = 64'(pairs_ff);
            st_in = ST_MDIV;
         end
         ST_MDIV: if (!dbusy) begin
            if (norm_ff == 0) begin
               score_in = (dq != 0) ? SCORE_ONE : 17'd0; st_in = ST_MUL1;
            end else begin
               dreq.start = 1'b1; dreq.num = dq << 16; dreq.den = 64'(norm_ff);
               st_in = ST_SDIV;
            end
         end
         ST_SDIV: if (!dbusy) begin
            score_in = (dq > 64'(SCORE_ONE)) ? SCORE_ONE : dq[16:0];
            st_in = ST_MUL1;
         end
         ST_MUL1: begin
            // shift-add: score*weight, multiplier bits serially
            acc_in = '0; mc_in = 64'(score_ff); mp_in = 32'(wgt_ff);
            mcnt_in = 6'd18; st_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (mcnt_ff != 6'd0) begin
               if (mp_ff[0]) acc_in = acc_ff + mc_ff;
               mc_in = mc_ff << 1; mp_in = mp_ff >> 1; mcnt_in = mcnt_ff - 6'd1;
            end else if (mp_ff == 32'd1) begin
               st_in = ST_RDIV; // second pass done
            end else begin
               mc_in = acc_ff; acc_in = '0; mp_in = 32'(d12); mcnt_in = 6'd12;
               // flag second pass by a sentinel bit above d
               mp_in[12] = 1'b1;
            end
         end
         ST_RDIV: st_in = ST_OUT;
         // the response register is loaded only once the previous response has left
         ST_OUT: if (!rsp_valid_ff) begin
            red = 14'((acc_ff + 64'hFFFF_FFFF) >> 32);
            effmax = $signed({4'b0, max_ff}) - $signed({2'b0, red});
            spd = ($signed({4'b0, errspd_ff}) < effmax) ? $signed({4'b0, errspd_ff})
                                                        : effmax;
            if (spd < $signed({4'b0, min_ff})) spd = $signed({4'b0, min_ff});
            if (min_ff >= max_ff) spd = $signed({4'b0, min_ff});
            rsp_data_in = {score_ff, 12'(spd)};
            rsp_valid_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) pabs_ff <= pin_abs[15:0] | {pin_abs[16], 15'b0};
      if (reset) begin
         min_ff <= '0; max_ff <= 12'd4095; thr_ff <= 15'd32767;
         wgt_ff <= 18'd32768; norm_ff <= 32'd65536;
         wp_ff <= '0; fill_ff <= '0; st_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MIN_SPEED: min_ff <= csr_wdata[11:0];
               REG_MAX_SPEED: max_ff <= csr_wdata[11:0];
               REG_THRESHOLD: thr_ff <= csr_wdata[14:0];
               REG_WEIGHT:    wgt_ff <= csr_wdata[17:0];
               REG_NORM:      norm_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            wp_ff <= wp_ff + PTR_W'(1);
            if (fill_ff < CNT_W'(WINDOW_DEPTH)) fill_ff <= fill_ff + CNT_W'(1);
         end
         st_ff <= st_in; rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in; pairs_ff <= pairs_in; sum_ff <= sum_in; score_ff <= score_in;
      acc_ff <= acc_in; mc_ff <= mc_in; mp_ff <= mp_in; mcnt_ff <= mcnt_in;
      errspd_ff <= errspd_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b0, rsp_data_ff};

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[28:12] <= SCORE_ONE) else $error("score above one");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !dbusy) else $error("divider busy while idle");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW_DEPTH)) else $error("fill count overflow");
endmodule

FILE: rtl/clsp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on clsp_pkg.
module clsp_div (
   input  logic clock,
   input  logic reset,
   input  clsp_pkg::div_req_type div_req,
   output logic busy,
   output logic [clsp_pkg::DIV_W-1:0] quot,
   output logic [clsp_pkg::DIV_W-1:0] remd
);
   import clsp_pkg::*;
   logic [DIV_W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [DIV_W:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      trial = {r_ff, q_ff[DIV_W-1]} - {1'b0, d_ff};
      if (div_req.start) begin
         q_in = div_req.num; r_in = '0; d_in = div_req.den; cnt_in = 7'(DIV_W);
      end else if (cnt_ff != 7'd0) begin
         if (!trial[DIV_W]) begin
            r_in = trial[DIV_W-1:0]; q_in = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DIV_W-2:0], q_ff[DIV_W-1]}; q_in = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end
   assign busy = (cnt_ff != 7'd0);
   assign quot = q_ff;
   assign remd = r_ff;
endmodule
